// ===== rtl/core/apf_pkg.sv =====
package apf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;
   localparam int COEF_BITS   = 16;
   localparam int MIN_BITS    = 15;

   // Envelope word and the widths of the blend arithmetic.
   localparam int ENV_W  = SAMPLE_BITS + FRAC_BITS;
   localparam int TERM_W = SAMPLE_BITS + COEF_BITS + 2;
   localparam int PROD_W = TERM_W + FRAC_BITS;
   localparam int CSR_W  = COEF_BITS;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      CSR_ATTACK  = 2'd0,
      CSR_RELEASE = 2'd1,
      CSR_MIN     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] attack_coef;
      logic [COEF_BITS-1:0] release_coef;
      logic [MIN_BITS-1:0]  min_level;
   } cfg_type;

   // One queued sample with its precomputed (1 - attack) * sample term.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic signed [TERM_W-1:0]      term;
   } entry_type;

endpackage

// ===== rtl/core/attack_release_peak_follower.sv =====
// Path from an accepted request beat to its response beat: input stage,
// queue, envelope and output registers, in that order.
// Throughput: one sample per cycle while the response side does not stall; the
// envelope update is a registered recurrence through a multiply and add per envelope.
// Reset (synchronous, active high) clears both envelopes, the coefficient
// registers, the queue and all valid flags.
module attack_release_peak_follower
   import apf_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [CSR_W-1:0]              csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_peak_hi,
   output logic signed [SAMPLE_BITS-1:0] rsp_peak_lo
);

   cfg_type   cfg_ff;
   logic      push, queue_full, pop, not_empty;
   entry_type push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ATTACK: begin
               cfg_ff.attack_coef <= csr_wdata[COEF_BITS-1:0];
            end
            CSR_RELEASE: begin
               cfg_ff.release_coef <= csr_wdata[COEF_BITS-1:0];
            end
            CSR_MIN: begin
               cfg_ff.min_level <= csr_wdata[MIN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   apf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   apf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry)
   );

   apf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .not_empty   (not_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_peak_hi (rsp_peak_hi),
      .rsp_peak_lo (rsp_peak_lo)
   );

endmodule

// ===== rtl/core/apf_front.sv =====
module apf_front
   import apf_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          push,
   output entry_type                     push_entry,
   input  logic                          queue_full
);

   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [TERM_W-1:0]      term_ff, term_in;
   logic signed [COEF_BITS+1:0]   weight;
   logic                          accept;

   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !queue_full;

   // The sample's weight in the blend is one minus the attack coefficient.
   assign weight  = {2'b01, {COEF_BITS{1'b0}}} - {2'b00, cfg.attack_coef};
   assign term_in = TERM_W'(weight) * TERM_W'(req_sample);

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
         term_ff   <= term_in;
      end
   end

   assign push_entry.sample = sample_ff;
   assign push_entry.term   = term_ff;

endmodule

// ===== rtl/core/apf_queue.sv =====
module apf_queue
   import apf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_entry
);

   entry_type            slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]    count_ff, count_in;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/apf_back.sv =====
module apf_back
   import apf_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          not_empty,
   input  entry_type                     pop_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_peak_hi,
   output logic signed [SAMPLE_BITS-1:0] rsp_peak_lo
);

   localparam int THR_W = MIN_BITS + FRAC_BITS;
   localparam int CMP_W = (ENV_W > THR_W) ? ENV_W : THR_W;

   logic signed [ENV_W-1:0]       upper_ff, upper_in;
   logic signed [ENV_W-1:0]       lower_ff, lower_in;
   logic                          env_valid_ff, env_valid_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] high_ff, high_in;
   logic signed [SAMPLE_BITS-1:0] low_ff, low_in;
   logic                          out_load;
   logic signed [ENV_W-1:0]       x;
   logic signed [PROD_W-1:0]      term;

   // Divide by 2^COEF_BITS, truncating toward zero.
   function automatic logic signed [ENV_W-1:0] trunc_coef(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] q;
      logic                     fix;
      q   = v >>> COEF_BITS;
      fix = v[PROD_W-1] && (v[COEF_BITS-1:0] != '0);
      return ENV_W'(q + {{(PROD_W-1){1'b0}}, fix});
   endfunction

   // One envelope step: blend toward the sample or decay by the release factor.
   function automatic logic signed [ENV_W-1:0] step(
      input logic signed [ENV_W-1:0]  env,
      input logic                     track,
      input logic signed [PROD_W-1:0] sample_term,
      input logic [COEF_BITS-1:0]     a,
      input logic [COEF_BITS-1:0]     r
   );
      logic signed [COEF_BITS:0] a_ext;
      logic signed [COEF_BITS:0] r_ext;
      logic signed [PROD_W-1:0]  blend_sum;
      logic signed [PROD_W-1:0]  decay;
      a_ext     = {1'b0, a};
      r_ext     = {1'b0, r};
      blend_sum = PROD_W'(a_ext) * PROD_W'(env) + sample_term;
      decay     = PROD_W'(r_ext) * PROD_W'(env);
      return trunc_coef(track ? blend_sum : decay);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] gate(
      input logic signed [ENV_W-1:0] env,
      input logic [MIN_BITS-1:0]     min_level
   );
      logic [ENV_W-1:0]       mag;
      logic [CMP_W-1:0]       thr;
      logic signed [ENV_W-1:0] q;
      logic                   fix;
      mag = env[ENV_W-1] ? ENV_W'(-env) : ENV_W'(env);
      thr = CMP_W'({min_level, {FRAC_BITS{1'b0}}});
      q   = env >>> FRAC_BITS;
      fix = env[ENV_W-1] && (env[FRAC_BITS-1:0] != '0);
      if (CMP_W'(mag) < thr) begin
         return '0;
      end
      return SAMPLE_BITS'(q + {{(ENV_W-1){1'b0}}, fix});
   endfunction

   assign x    = {pop_entry.sample, {FRAC_BITS{1'b0}}};
   assign term = {pop_entry.term, {FRAC_BITS{1'b0}}};

   // The envelope registers hold the item in the first stage; the output
   // register takes the gated copy when that item moves on.
   assign out_load = env_valid_ff && (!out_valid_ff || !rsp_stall);
   assign pop      = not_empty && (!env_valid_ff || out_load);

   always_comb begin
      upper_in = upper_ff;
      lower_in = lower_ff;
      if (pop) begin
         upper_in = step(upper_ff, x > upper_ff, term, cfg.attack_coef, cfg.release_coef);
         lower_in = step(lower_ff, x < lower_ff, term, cfg.attack_coef, cfg.release_coef);
      end
   end

   always_comb begin
      env_valid_in = env_valid_ff;
      if (pop) begin
         env_valid_in = 1'b1;
      end else if (out_load) begin
         env_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   assign high_in = gate(upper_ff, cfg.min_level);
   assign low_in  = gate(lower_ff, cfg.min_level);

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= '0;
         lower_ff     <= '0;
         env_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
         env_valid_ff <= env_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         high_ff <= high_in;
         low_ff  <= low_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_peak_hi = high_ff;
   assign rsp_peak_lo = low_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import apf_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int HOLD_CYCLES = 60;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] peak_hi;
      logic signed [SAMPLE_BITS-1:0] peak_lo;
   } peaks_type;

   typedef struct packed {
      logic                          is_write;
      logic [1:0]                    index;
      logic [CSR_W-1:0]              wdata;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          typed;
      peaks_type                     peaks;
   } step_row_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_write;
   logic [1:0]                    csr_index;
   logic [CSR_W-1:0]              csr_wdata;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_peak_hi;
   logic signed [SAMPLE_BITS-1:0] rsp_peak_lo;

   // Shadow of the block: coefficient registers and both envelopes in Q16.16.
   int unsigned attack_w = 0;
   int unsigned release_w = 0;
   int unsigned min_w = 0;
   longint upper_env = 0;
   longint lower_env = 0;

   peaks_type expected_peaks[$];
   int failures = 0;
   int quiet_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int hold_count = 0;

   attack_release_peak_follower u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_peak_hi (rsp_peak_hi),
      .rsp_peak_lo (rsp_peak_lo)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Divide by 2^n, truncating toward zero.
   function automatic longint toward_zero(input longint v, input int n);
      longint m;
      m = (v < 0) ? -v : v;
      m = m >> n;
      return (v < 0) ? -m : m;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] gate_peak(input longint env);
      longint mag;
      longint whole;
      mag = (env < 0) ? -env : env;
      if (mag < (longint'(min_w) << FRAC_BITS))
         return '0;
      whole = toward_zero(env, FRAC_BITS);
      return whole[SAMPLE_BITS-1:0];
   endfunction

   function automatic peaks_type follow_envelopes(input logic signed [SAMPLE_BITS-1:0] s);
      longint x;
      longint keep;
      longint take;
      peaks_type p;
      x = longint'(s) * (longint'(1) << FRAC_BITS);
      keep = longint'(attack_w);
      take = (longint'(1) << COEF_BITS) - keep;
      if (x > upper_env)
         upper_env = toward_zero(keep * upper_env + take * x, COEF_BITS);
      else
         upper_env = toward_zero(upper_env * longint'(release_w), COEF_BITS);
      if (x < lower_env)
         lower_env = toward_zero(keep * lower_env + take * x, COEF_BITS);
      else
         lower_env = toward_zero(lower_env * longint'(release_w), COEF_BITS);
      p.peak_hi = gate_peak(upper_env);
      p.peak_lo = gate_peak(lower_env);
      return p;
   endfunction

   function automatic step_row_type reg_row(input logic [1:0] index,
                                            input logic [CSR_W-1:0] value);
      step_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.index = index;
      r.wdata = value;
      return r;
   endfunction

   function automatic step_row_type beat_row(input int s, input bit typed,
                                             input int hi, input int lo);
      step_row_type r;
      r = '0;
      r.sample = s[SAMPLE_BITS-1:0];
      r.typed = typed;
      r.peaks.peak_hi = hi[SAMPLE_BITS-1:0];
      r.peaks.peak_lo = lo[SAMPLE_BITS-1:0];
      return r;
   endfunction

   function automatic logic [CSR_W-1:0] pick_coef();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return 16'hFFFF - 16'($urandom_range(4095));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic note_failure(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      failures++;
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_ATTACK:  attack_w = 32'(value);
         CSR_RELEASE: release_w = 32'(value);
         CSR_MIN:     min_w = 32'(value[MIN_BITS-1:0]);
         default: ;
      endcase
   endtask

   // Offers one sample beat and records its expected peaks once it is taken.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit use_typed,
                              input peaks_type typed_peaks);
      peaks_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = follow_envelopes(s);
      expected_peaks.push_back(use_typed ? typed_peaks : predicted);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_peaks.size() != 0)
         @(posedge clock);
   endtask

   initial begin : receiver
      int hold_seen;
      hold_seen = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_count != hold_seen) begin
            // Long hold-off so the queue inside the block fills and stalls the input.
            hold_seen = hold_count;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      peaks_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_peaks.size() == 0) begin
            note_failure($sformatf("unexpected result beat hi %0d lo %0d",
                                   rsp_peak_hi, rsp_peak_lo));
         end else begin
            want = expected_peaks.pop_front();
            if (rsp_peak_hi !== want.peak_hi)
               note_failure($sformatf("peak_hi got %0d want %0d",
                                      rsp_peak_hi, want.peak_hi));
            if (rsp_peak_lo !== want.peak_lo)
               note_failure($sformatf("peak_lo got %0d want %0d",
                                      rsp_peak_lo, want.peak_lo));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      step_row_type directed[$];
      logic [CSR_W-1:0] a_coef;
      logic [CSR_W-1:0] r_coef;
      logic [CSR_W-1:0] m_word;
      logic signed [SAMPLE_BITS-1:0] s;
      int amp;
      int v;
      int n;

      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_ATTACK;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_sample = '0;

      // Reset settings: attack zero jumps to the sample, release zero clears at once.
      directed.push_back(beat_row(32767, 1, 32767, 0));
      directed.push_back(beat_row(-32768, 1, 0, -32768));
      directed.push_back(beat_row(0, 1, 0, 0));
      directed.push_back(beat_row(1, 1, 1, 0));
      directed.push_back(beat_row(-1, 1, 0, -1));
      directed.push_back(beat_row(21845, 1, 21845, 0));
      directed.push_back(beat_row(-21846, 1, 0, -21846));
      // Minimum level 100 with the unused top bit set; equality passes.
      directed.push_back(reg_row(CSR_MIN, 16'h8064));
      directed.push_back(beat_row(100, 1, 100, 0));
      directed.push_back(beat_row(99, 1, 0, 0));
      directed.push_back(beat_row(-100, 1, 0, -100));
      directed.push_back(beat_row(-99, 1, 0, 0));
      // Slowest attack and release, no gating.
      directed.push_back(reg_row(CSR_ATTACK, 16'hFFFF));
      directed.push_back(reg_row(CSR_RELEASE, 16'hFFFF));
      directed.push_back(reg_row(CSR_MIN, 16'h0000));
      directed.push_back(beat_row(32767, 0, 0, 0));
      directed.push_back(beat_row(32767, 0, 0, 0));
      directed.push_back(beat_row(-32768, 0, 0, 0));
      directed.push_back(beat_row(-32768, 0, 0, 0));
      directed.push_back(beat_row(0, 0, 0, 0));
      // Half-way coefficients; negative envelopes truncate toward zero.
      directed.push_back(reg_row(CSR_ATTACK, 16'h8000));
      directed.push_back(reg_row(CSR_RELEASE, 16'h8000));
      directed.push_back(reg_row(CSR_SPARE, 16'hFFFF));
      directed.push_back(beat_row(1000, 0, 0, 0));
      directed.push_back(beat_row(-1000, 0, 0, 0));
      directed.push_back(beat_row(0, 0, 0, 0));
      directed.push_back(beat_row(0, 0, 0, 0));
      directed.push_back(beat_row(0, 0, 0, 0));
      // Largest minimum level with instant attack and release.
      directed.push_back(reg_row(CSR_ATTACK, 16'h0000));
      directed.push_back(reg_row(CSR_RELEASE, 16'h0000));
      directed.push_back(reg_row(CSR_MIN, 16'h7FFF));
      directed.push_back(beat_row(32767, 1, 32767, 0));
      directed.push_back(beat_row(-32768, 1, 0, -32768));
      directed.push_back(beat_row(32766, 1, 0, 0));
      directed.push_back(beat_row(-32767, 1, 0, -32767));

      send_idle_pct = 23;
      recv_stall_pct <= 61;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_write) begin
            settle();
            write_reg(directed[i].index, directed[i].wdata);
         end else begin
            send_sample(directed[i].sample, directed[i].typed, directed[i].peaks);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 23;
               recv_stall_pct <= 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_stall_pct <= 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct <= 0;
            end
         endcase
         for (int blk = 0; blk < 6; blk++) begin
            settle();
            case (blk)
               0: begin
                  a_coef = '1;
                  r_coef = '1;
                  m_word = '0;
               end
               1: begin
                  a_coef = '0;
                  r_coef = '0;
                  m_word = 16'h7FFF;
               end
               default: begin
                  a_coef = pick_coef();
                  r_coef = pick_coef();
                  case ($urandom_range(3))
                     0: m_word = '0;
                     1: m_word = 16'($urandom_range(255));
                     2: m_word = 16'($urandom_range(32767));
                     default: m_word = 16'h7FFF;
                  endcase
               end
            endcase
            m_word[CSR_W-1] = 1'($urandom_range(1));
            write_reg(CSR_ATTACK, a_coef);
            write_reg(CSR_RELEASE, r_coef);
            write_reg(CSR_MIN, m_word);
            if ($urandom_range(3) == 0)
               write_reg(CSR_SPARE, 16'($urandom));

            amp = $urandom_range(1, 32767);
            n = $urandom_range(50, 95);
            for (int k = 0; k < n; k++) begin
               if (phase == 2 && blk == 2 && k == 10)
                  hold_count <= hold_count + 1;
               case ($urandom_range(9))
                  0: s = 16'($urandom);
                  1: s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                  2: s = '0;
                  default: begin
                     v = int'($urandom_range(2 * amp)) - amp;
                     s = v[SAMPLE_BITS-1:0];
                  end
               endcase
               send_sample(s, 1'b0, '0);
            end
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/apf_pkg.sv
rtl/core/apf_front.sv
rtl/core/apf_queue.sv
rtl/core/apf_back.sv
rtl/core/attack_release_peak_follower.sv
test/tb.sv
